### hdl/majority_color_downscaler_defines.svh
// Assertion macros for the downscaler, clocked on clk, off while arst_n is low.
`ifndef MAJORITY_COLOR_DOWNSCALER_DEFINES_SVH
`define MAJORITY_COLOR_DOWNSCALER_DEFINES_SVH

// same-cycle implication
`define MCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mcd_pkg.sv
package mcd_pkg;

	localparam int COLOR_W = 4;
	localparam int DIM_W   = 8;
	localparam int ORDER_W = 3;
	localparam int CNT_W   = 9;
	localparam int POS_W   = 8;
	localparam int SLOT_MAX_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHRINK_ORDER = 2'd2;

	// one accepted pixel, decoded against the frame counters
	typedef struct packed {
		logic                  inblk;  // inside a full block
		logic                  clear;  // first pixel of this slot in the band
		logic                  first;  // top-left pixel of the block
		logic                  emit;   // bottom-right pixel of the block
		logic                  last;   // final block of the frame
		logic [SLOT_MAX_W-1:0] slot;
		logic [COLOR_W-1:0]    color;
		logic [POS_W-1:0]      pos;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [POS_W-1:0] first;
	} bin_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [CNT_W-1:0]   cnt;
		logic [POS_W-1:0]   first;
	} leader_t;

endpackage

### hdl/majority_color_downscaler.sv
// Mode downscaler for 4-bit palette images by 2^k in each dimension.
// Configure image_width, image_height and shrink_order through the write
// port while the block is idle; writing any of the three restarts the frame.
// Pixels enter in raster order on pixel_valid/pixel_ready. Each full
// 2^k x 2^k block yields one item on out_valid/out_ready carrying its most
// frequent color; out_last flags the final block of the frame. Pixels past
// the last full block row or column are taken and give nothing.
// Throughput: one pixel per cycle when the output does not stall. A result
// goes from its bottom-right pixel to out_valid through the memory read on
// the accepting edge and the count/leader update into the output register.
// Per-slot/color counts and per-slot leaders live in two memories with a
// registered read; back-to-back hits on the same entry are forwarded.
// Reset: registers return to 1/1/1 and the counters clear; no memory sweep.
// Output stall: the update stage holds while a waiting result is not taken
// and the pixel in that stage would also produce one; pixel_ready drops then.
`include "majority_color_downscaler_defines.svh"

module majority_color_downscaler #(
	parameter int COLUMN_SLOTS = 256,
	parameter int COLORS = 16,
	parameter int MAX_SHIFT = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcd_pkg::DIM_W-1:0]          cfg_data,
	input  logic                               pixel_valid,
	output logic                               pixel_ready,
	input  logic [mcd_pkg::COLOR_W-1:0]        pixel_color,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mcd_pkg::COLOR_W-1:0]        out_color,
	output logic                               out_last
);
	mcd_pkg::item_t item;
	logic           fire;

	assign fire = pixel_valid && pixel_ready;

	mcd_front #(
		.COLUMN_SLOTS(COLUMN_SLOTS),
		.COLORS(COLORS),
		.MAX_SHIFT(MAX_SHIFT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_color(pixel_color),
		.fire(fire),
		.item(item)
	);

	mcd_update #(
		.COLUMN_SLOTS(COLUMN_SLOTS),
		.COLORS(COLORS)
	) u_update (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item),
		.in_ready(pixel_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_color(out_color),
		.out_last(out_last)
	);

	// input only backs up behind a result that is held at the output
	`MCD_ASSERT_NOW(a_stall_cause, !pixel_ready, out_valid && !out_ready, "stall without held result")
	// a new result on out_valid needs an item accepted into the update stage before it
	`MCD_ASSERT_NEXT(a_no_phantom, !fire, ##1 !$rose(out_valid), "result without item")

endmodule

### hdl/mcd_front.sv
module mcd_front #(
	parameter int COLUMN_SLOTS = 256,
	parameter int COLORS = 16,
	parameter int MAX_SHIFT = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcd_pkg::DIM_W-1:0]          cfg_data,
	input  logic [mcd_pkg::COLOR_W-1:0]        pixel_color,
	input  logic                               fire,
	output mcd_pkg::item_t                     item
);
	localparam int SLOT_W = $clog2(COLUMN_SLOTS);

	logic [mcd_pkg::DIM_W-1:0]   w_q, h_q, x_q, y_q;
	logic [mcd_pkg::ORDER_W-1:0] so_q, k_q;
	logic [SLOT_W-1:0]           slot_q;

	logic [mcd_pkg::DIM_W-1:0]   w_n, h_n, w1, h1, wd, hd, nw, nh;
	logic [mcd_pkg::ORDER_W-1:0] so_n, k_n;
	logic                        restart;
	logic [mcd_pkg::DIM_W-1:0]   edge_m, ox, oy, bx, by;
	logic [mcd_pkg::COLOR_W-1:0] cw;

	// effective order for the registers as they stand after this write
	always_comb begin
		w_n = (cfg_wr_en && cfg_index == mcd_pkg::REG_IMAGE_WIDTH) ? cfg_data : w_q;
		h_n = (cfg_wr_en && cfg_index == mcd_pkg::REG_IMAGE_HEIGHT) ? cfg_data : h_q;
		so_n = (cfg_wr_en && cfg_index == mcd_pkg::REG_SHRINK_ORDER) ?
			cfg_data[mcd_pkg::ORDER_W-1:0] : so_q;
		restart = cfg_wr_en && (cfg_index == mcd_pkg::REG_IMAGE_WIDTH ||
			cfg_index == mcd_pkg::REG_IMAGE_HEIGHT || cfg_index == mcd_pkg::REG_SHRINK_ORDER);
		w1 = (w_n == '0) ? 8'd1 : w_n;
		h1 = (h_n == '0) ? 8'd1 : h_n;
		k_n = (so_n > mcd_pkg::ORDER_W'(MAX_SHIFT)) ? mcd_pkg::ORDER_W'(MAX_SHIFT) : so_n;
		for (int i = 0; i < 4; i++) begin
			if (k_n != '0 && ((w1 >> k_n) == '0 || (h1 >> k_n) == '0))
				k_n = k_n - 3'd1;
		end
	end

	always_comb begin
		wd = (w_q == '0) ? 8'd1 : w_q;
		hd = (h_q == '0) ? 8'd1 : h_q;
		nw = wd >> k_q;
		nh = hd >> k_q;
		edge_m = ~(8'hFF << k_q);
		ox = x_q & edge_m;
		oy = y_q & edge_m;
		bx = x_q >> k_q;
		by = y_q >> k_q;
		cw = pixel_color;
		for (int i = 0; i < 8; i++) begin
			if (5'(cw) >= 5'(COLORS))
				cw = cw - mcd_pkg::COLOR_W'(COLORS);
		end
		item.inblk = (x_q < (nw << k_q)) && (y_q < (nh << k_q));
		item.pos   = (oy << k_q) | ox;
		item.first = (item.pos == '0);
		item.clear = item.first && (9'(bx) < 9'(COLUMN_SLOTS));
		item.emit  = (ox == edge_m) && (oy == edge_m);
		item.last  = (bx == nw - 8'd1) && (by == nh - 8'd1);
		item.slot  = mcd_pkg::SLOT_MAX_W'(slot_q);
		item.color = cw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 8'd1;
			h_q <= 8'd1;
			so_q <= 3'd1;
			k_q <= '0;
			x_q <= '0;
			y_q <= '0;
			slot_q <= '0;
		end else if (restart) begin
			w_q <= w_n;
			h_q <= h_n;
			so_q <= so_n;
			k_q <= k_n;
			x_q <= '0;
			y_q <= '0;
			slot_q <= '0;
		end else if (fire) begin
			if (9'(x_q) + 9'd1 >= 9'(wd)) begin
				x_q <= '0;
				slot_q <= '0;
				y_q <= (9'(y_q) + 9'd1 >= 9'(hd)) ? '0 : y_q + 8'd1;
			end else begin
				x_q <= x_q + 8'd1;
				// slot follows the column block, wrapping over the slot count
				if (ox == edge_m)
					slot_q <= (slot_q == SLOT_W'(COLUMN_SLOTS - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

endmodule

### hdl/mcd_update.sv
module mcd_update #(
	parameter int COLUMN_SLOTS = 256,
	parameter int COLORS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  mcd_pkg::item_t              item,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mcd_pkg::COLOR_W-1:0] out_color,
	output logic                        out_last
);
	localparam int SLOT_W = $clog2(COLUMN_SLOTS);
	localparam int BIN_DEPTH = COLUMN_SLOTS * COLORS;
	localparam int BIN_AW = $clog2(BIN_DEPTH);
	localparam int CIDX_W = $clog2(COLORS);
	localparam int LEAD_W = $bits(mcd_pkg::leader_t);
	localparam int SENT_W = COLORS + LEAD_W;

	// bin memory: count and first position per slot and color
	// slot memory: colors seen in the current band, and the block leader
	mcd_pkg::bin_t     bin_mem [BIN_DEPTH];
	logic [SENT_W-1:0] slot_mem [COLUMN_SLOTS];

	logic [BIN_AW-1:0] bin_addr0, bin_addr_s1, fwd_bin_addr_q;
	logic [SLOT_W-1:0] slot0, slot_s1, fwd_slot_q;
	mcd_pkg::item_t    item_s1;
	logic              v_s1, fwd_v_q, out_v_q, advance, wr_en;
	mcd_pkg::bin_t     bin_rd_q, fwd_bin_q, bin_cur, bin_new;
	logic [SENT_W-1:0] slot_rd_q, fwd_slot_data_q, slot_cur, slot_new;
	logic [COLORS-1:0] mask_base, mask_new;
	logic [CIDX_W-1:0] cidx;
	mcd_pkg::leader_t  lead_old, lead_new;
	logic [mcd_pkg::CNT_W-1:0] cnt;
	logic [mcd_pkg::POS_W-1:0] first_pos;
	logic [mcd_pkg::COLOR_W-1:0] out_color_q;
	logic              out_last_q;

	assign slot0 = item.slot[SLOT_W-1:0];
	assign bin_addr0 = BIN_AW'(slot0 * COLORS + item.color);
	assign advance = !v_s1 || !item_s1.emit || !out_v_q || out_ready;
	assign in_ready = advance;
	assign wr_en = advance && v_s1;

	always_comb begin
		// previous item's write lands on the same edge as this item's read
		bin_cur = (fwd_v_q && fwd_bin_addr_q == bin_addr_s1) ? fwd_bin_q : bin_rd_q;
		slot_cur = (fwd_v_q && fwd_slot_q == slot_s1) ? fwd_slot_data_q : slot_rd_q;
		cidx = item_s1.color[CIDX_W-1:0];
		mask_base = item_s1.clear ? '0 : slot_cur[SENT_W-1:LEAD_W];
		lead_old = slot_cur[LEAD_W-1:0];
		if (mask_base[cidx]) begin
			cnt = bin_cur.cnt;
			first_pos = bin_cur.first;
		end else begin
			cnt = '0;
			first_pos = item_s1.pos;
		end
		if (cnt != mcd_pkg::COUNT_MAX)
			cnt = cnt + 9'd1;
		bin_new.cnt = cnt;
		bin_new.first = first_pos;
		mask_new = mask_base | (COLORS'(1) << cidx);
		if (item_s1.first || cnt > lead_old.cnt ||
			(cnt == lead_old.cnt && first_pos < lead_old.first)) begin
			lead_new.color = item_s1.color;
			lead_new.cnt = cnt;
			lead_new.first = first_pos;
		end else begin
			lead_new = lead_old;
		end
		slot_new = {mask_new, lead_new};
	end

	always_ff @(posedge clk) begin
		if (fire && item.inblk) begin
			bin_rd_q <= bin_mem[bin_addr0];
			slot_rd_q <= slot_mem[slot0];
		end
		if (wr_en) begin
			bin_mem[bin_addr_s1] <= bin_new;
			slot_mem[slot_s1] <= slot_new;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			item_s1 <= item;
			bin_addr_s1 <= bin_addr0;
			slot_s1 <= slot0;
		end
		if (advance) begin
			fwd_bin_addr_q <= bin_addr_s1;
			fwd_slot_q <= slot_s1;
			fwd_bin_q <= bin_new;
			fwd_slot_data_q <= slot_new;
		end
		if (wr_en && item_s1.emit) begin
			out_color_q <= lead_new.color;
			out_last_q <= item_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (fire)
				v_s1 <= item.inblk;
			else if (advance)
				v_s1 <= 1'b0;
			if (advance)
				fwd_v_q <= v_s1;
			if (wr_en && item_s1.emit)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	assign out_valid = out_v_q;
	assign out_color = out_color_q;
	assign out_last = out_last_q;

endmodule
